>>> rtl/lgpf_pkg.sv
// shared types, constants and helpers of the linear gradient pixel filler
`timescale 1ns / 1ps
`default_nettype none
package lgpf_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = 13;
  localparam int POS_W    = 12;
  localparam int IDX_W    = 24;
  localparam int TOTAL_W  = 25;
  localparam int COLOR_W  = 32;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int OP_W     = 2;
  localparam int PROD_W   = CH_W + POS_W;
  localparam int CNT_W    = 5;
  localparam int DCNT_W   = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SOLID  = 2'd0,
    OP_GRAD   = 2'd1,
    OP_REWIND = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    K_SOLID,
    K_GRAD,
    K_REWIND,
    K_NOP
  } kind_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_START  = 3'd2,
    REG_END    = 3'd3,
    REG_VERT   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COORD,
    BK_MUL,
    BK_DIV
  } bk_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  w;
    logic [SIDE_W-1:0]  h;
    logic [TOTAL_W-1:0] total;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic               vert;
    logic               width_wr;
  } cfg_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lgpf_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface lgpf_in_if;
  logic                                valid;
  logic                                ready;
  logic [lgpf_pkg::OP_W-1:0]           op;
  logic [lgpf_pkg::COLOR_W-1:0]        pixel_color;
  modport source(output valid, output op, output pixel_color, input ready);
  modport sink(input valid, input op, input pixel_color, output ready);
endinterface

interface lgpf_out_if;
  logic                                valid;
  logic                                ready;
  logic [lgpf_pkg::IDX_W-1:0]          pixel_address;
  logic [lgpf_pkg::COLOR_W-1:0]        pixel_value;
  logic                                written;
  logic                                image_done;
  modport source(output valid, output pixel_address, output pixel_value,
                 output written, output image_done, input ready);
  modport sink(input valid, input pixel_address, input pixel_value,
               input written, input image_done, output ready);
endinterface
`default_nettype wire

>>> rtl/lgpf_cfg.sv
// apb configuration registers with clamped sizes and pixel total
`timescale 1ns / 1ps
`default_nettype none
module lgpf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgpf_pkg::ADDR_W-1:0]   paddr,
  input  logic [lgpf_pkg::DATA_W-1:0]   pwdata,
  output logic [lgpf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lgpf_pkg::cfg_t                cfg
);

  logic [lgpf_pkg::SIDE_W-1:0]  width_r;
  logic [lgpf_pkg::SIDE_W-1:0]  height_r;
  logic [lgpf_pkg::COLOR_W-1:0] start_r;
  logic [lgpf_pkg::COLOR_W-1:0] end_r;
  logic                         vert_r;
  logic [lgpf_pkg::TOTAL_W-1:0] total_r;
  logic [lgpf_pkg::TOTAL_W-1:0] total_nxt;
  logic [lgpf_pkg::SIDE_W-1:0]  w_cl;
  logic [lgpf_pkg::SIDE_W-1:0]  h_cl;
  logic [2:0]                   reg_sel;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  assign w_cl      = lgpf_pkg::clamp_side(width_r);
  assign h_cl      = lgpf_pkg::clamp_side(height_r);
  assign total_nxt = lgpf_pkg::TOTAL_W'(w_cl) * lgpf_pkg::TOTAL_W'(h_cl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lgpf_pkg::SIDE_W'(1);
      height_r <= lgpf_pkg::SIDE_W'(1);
      start_r  <= '0;
      end_r    <= '0;
      vert_r   <= 1'b0;
      total_r  <= lgpf_pkg::TOTAL_W'(1);
    end else begin
      total_r <= total_nxt;
      if (wr_en) begin
        case (reg_sel)
          lgpf_pkg::REG_WIDTH:  width_r  <= pwdata[lgpf_pkg::SIDE_W-1:0];
          lgpf_pkg::REG_HEIGHT: height_r <= pwdata[lgpf_pkg::SIDE_W-1:0];
          lgpf_pkg::REG_START:  start_r  <= pwdata;
          lgpf_pkg::REG_END:    end_r    <= pwdata;
          lgpf_pkg::REG_VERT:   vert_r   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      lgpf_pkg::REG_WIDTH:  prdata = lgpf_pkg::DATA_W'(width_r);
      lgpf_pkg::REG_HEIGHT: prdata = lgpf_pkg::DATA_W'(height_r);
      lgpf_pkg::REG_START:  prdata = start_r;
      lgpf_pkg::REG_END:    prdata = end_r;
      lgpf_pkg::REG_VERT:   prdata = lgpf_pkg::DATA_W'(vert_r);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    cfg.w           = w_cl;
    cfg.h           = h_cl;
    cfg.total       = total_r;
    cfg.start_color = start_r;
    cfg.end_color   = end_r;
    cfg.vert        = vert_r;
    cfg.width_wr    = wr_en && (reg_sel == lgpf_pkg::REG_WIDTH);
  end

endmodule
`default_nettype wire

>>> rtl/lgpf_front.sv
// request intake: op decode and a short command queue
`timescale 1ns / 1ps
`default_nettype none
module lgpf_front (
  input  logic            clk,
  input  logic            rst_n,
  lgpf_in_if.sink         in_ch,
  output logic            q_valid,
  output lgpf_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);

  lgpf_pkg::cmd_t                mem_r [lgpf_pkg::Q_DEPTH];
  logic [lgpf_pkg::QPTR_W-1:0]   wptr_r;
  logic [lgpf_pkg::QPTR_W-1:0]   rptr_r;
  logic [lgpf_pkg::QCNT_W-1:0]   cnt_r;
  logic [lgpf_pkg::QPTR_W-1:0]   wptr_nxt;
  logic [lgpf_pkg::QPTR_W-1:0]   rptr_nxt;
  logic [lgpf_pkg::QCNT_W-1:0]   cnt_nxt;
  lgpf_pkg::cmd_t                cmd_in;
  logic                          push;
  logic                          pop;

  always_comb begin
    cmd_in.color = in_ch.pixel_color;
    case (in_ch.op)
      lgpf_pkg::OP_SOLID:  cmd_in.kind = lgpf_pkg::K_SOLID;
      lgpf_pkg::OP_GRAD:   cmd_in.kind = lgpf_pkg::K_GRAD;
      lgpf_pkg::OP_REWIND: cmd_in.kind = lgpf_pkg::K_REWIND;
      default:             cmd_in.kind = lgpf_pkg::K_NOP;
    endcase
  end

  // no request is taken while reset is held
  assign in_ch.ready = rst_n && (cnt_r != lgpf_pkg::QCNT_W'(lgpf_pkg::Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_cmd       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lgpf_back.sv
// execution engine: pixel index, column/row recovery, ramp divide, result register
`timescale 1ns / 1ps
`default_nettype none
module lgpf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lgpf_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  lgpf_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  lgpf_out_if.source      out_ch
);

  localparam int IW = lgpf_pkg::IDX_W;
  localparam int PW = lgpf_pkg::POS_W;
  localparam int SW = lgpf_pkg::SIDE_W;
  localparam int TW = lgpf_pkg::TOTAL_W;
  localparam int CW = lgpf_pkg::CH_W;
  localparam int DW = lgpf_pkg::PROD_W;
  localparam int NC = lgpf_pkg::NUM_CH;

  lgpf_pkg::bk_state_t state_r, state_nxt;

  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          full_r, full_nxt;
  logic                          cvalid_r, cvalid_nxt;
  logic [PW-1:0]                 x_r, x_nxt;
  logic [PW-1:0]                 y_r, y_nxt;
  logic [IW-1:0]                 cdvd_r, cdvd_nxt;
  logic [PW-1:0]                 crem_r, crem_nxt;
  logic [lgpf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]                 size_r, size_nxt;
  logic [lgpf_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [DW-1:0]                 prod_r [NC];
  logic [DW-1:0]                 prod_nxt [NC];
  logic                          neg_r [NC];
  logic                          neg_nxt [NC];
  logic [CW-1:0]                 quo_r [NC];
  logic [CW-1:0]                 quo_nxt [NC];

  logic                          ovalid_r, ovalid_nxt;
  logic [IW-1:0]                 oaddr_r, oaddr_nxt;
  logic [lgpf_pkg::COLOR_W-1:0]  oval_r, oval_nxt;
  logic                          owr_r, owr_nxt;
  logic                          odone_r, odone_nxt;

  logic [TW-1:0]                 total_m1;
  logic                          writable;
  logic                          last;
  logic                          out_free;
  logic                          pop;
  logic                          commit;
  logic [lgpf_pkg::COLOR_W-1:0]  commit_val;
  logic [SW-1:0]                 ct;
  logic                          cge;
  logic [PW-1:0]                 crem_step;
  logic [IW-1:0]                 cdvd_step;
  logic [SW-1:0]                 x_inc;
  logic [PW-1:0]                 pos;
  logic [DW-1:0]                 sd;
  logic                          ge [NC];
  logic [CW-1:0]                 q_fin [NC];
  logic [DW-1:0]                 prod_mul [NC];
  logic                          neg_mul [NC];
  logic [lgpf_pkg::COLOR_W-1:0]  ramp_val;

  assign total_m1  = cfg.total - 1'b1;
  assign writable  = !full_r && ({1'b0, idx_r} < cfg.total);
  assign last      = ({1'b0, idx_r} == total_m1);
  assign out_free  = !ovalid_r || out_ch.ready;
  assign pop       = (state_r == lgpf_pkg::BK_IDLE) && q_valid && out_free;
  assign q_pop     = pop;

  // column/row recovery step: one quotient bit of index / width
  assign ct        = {crem_r, cdvd_r[IW-1]};
  assign cge       = (ct >= cfg.w);
  assign crem_step = cge ? PW'(ct - cfg.w) : ct[PW-1:0];
  assign cdvd_step = {cdvd_r[IW-2:0], cge};

  assign x_inc     = {1'b0, x_r} + 1'b1;
  assign pos       = cfg.vert ? y_r : x_r;
  assign sd        = DW'(size_r) << dcnt_r;

  always_comb begin
    logic [CW:0]   d;
    logic [CW-1:0] mag;
    logic [CW-1:0] c0;
    ramp_val = '0;
    for (int l = 0; l < NC; l++) begin
      d   = {1'b0, cfg.end_color[l*CW +: CW]} - {1'b0, cfg.start_color[l*CW +: CW]};
      mag = d[CW] ? CW'(~d + 1'b1) : d[CW-1:0];
      neg_mul[l]  = d[CW];
      prod_mul[l] = DW'(mag) * DW'(pos);
      ge[l]       = (prod_r[l] >= sd);
      q_fin[l]    = {quo_r[l][CW-2:0], ge[l]};
      c0          = cfg.start_color[l*CW +: CW];
      ramp_val[l*CW +: CW] = neg_r[l] ? c0 - q_fin[l] : c0 + q_fin[l];
    end
  end

  assign commit = (pop && writable && (q_cmd.kind == lgpf_pkg::K_SOLID)) ||
                  ((state_r == lgpf_pkg::BK_DIV) && (dcnt_r == '0));
  assign commit_val = (state_r == lgpf_pkg::BK_DIV) ? ramp_val : q_cmd.color;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgpf_pkg::BK_IDLE: begin
        if (pop && writable && (q_cmd.kind == lgpf_pkg::K_GRAD)) begin
          state_nxt = cvalid_r ? lgpf_pkg::BK_MUL : lgpf_pkg::BK_COORD;
        end
      end
      lgpf_pkg::BK_COORD: begin
        if (cnt_r == lgpf_pkg::CNT_W'(IW - 1)) begin
          state_nxt = lgpf_pkg::BK_MUL;
        end
      end
      lgpf_pkg::BK_MUL: state_nxt = lgpf_pkg::BK_DIV;
      lgpf_pkg::BK_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = lgpf_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lgpf_pkg::BK_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    idx_nxt    = idx_r;
    full_nxt   = full_r;
    cvalid_nxt = cvalid_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    cdvd_nxt   = cdvd_r;
    crem_nxt   = crem_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    dcnt_nxt   = dcnt_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    oaddr_nxt  = oaddr_r;
    oval_nxt   = oval_r;
    owr_nxt    = owr_r;
    odone_nxt  = odone_r;

    case (state_r)
      lgpf_pkg::BK_IDLE: begin
        if (pop) begin
          if (q_cmd.kind == lgpf_pkg::K_REWIND) begin
            ovalid_nxt = 1'b1;
            oaddr_nxt  = '0;
            oval_nxt   = '0;
            owr_nxt    = 1'b0;
            odone_nxt  = 1'b0;
            idx_nxt    = '0;
            full_nxt   = 1'b0;
            x_nxt      = '0;
            y_nxt      = '0;
            cvalid_nxt = 1'b1;
          end else if (!writable || (q_cmd.kind == lgpf_pkg::K_NOP)) begin
            ovalid_nxt = 1'b1;
            oaddr_nxt  = idx_r;
            oval_nxt   = '0;
            owr_nxt    = 1'b0;
            odone_nxt  = 1'b0;
          end else if ((q_cmd.kind == lgpf_pkg::K_GRAD) && !cvalid_r) begin
            cdvd_nxt = idx_r;
            crem_nxt = '0;
            cnt_nxt  = '0;
          end
        end
      end
      lgpf_pkg::BK_COORD: begin
        cdvd_nxt = cdvd_step;
        crem_nxt = crem_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == lgpf_pkg::CNT_W'(IW - 1)) begin
          x_nxt      = crem_step;
          y_nxt      = cdvd_step[PW-1:0];
          cvalid_nxt = 1'b1;
        end
      end
      lgpf_pkg::BK_MUL: begin
        size_nxt = cfg.vert ? cfg.h : cfg.w;
        dcnt_nxt = '1;
        for (int l = 0; l < NC; l++) begin
          prod_nxt[l] = prod_mul[l];
          neg_nxt[l]  = neg_mul[l];
          quo_nxt[l]  = '0;
        end
      end
      lgpf_pkg::BK_DIV: begin
        dcnt_nxt = dcnt_r - 1'b1;
        for (int l = 0; l < NC; l++) begin
          prod_nxt[l] = ge[l] ? prod_r[l] - sd : prod_r[l];
          quo_nxt[l]  = q_fin[l];
        end
      end
      default: ;
    endcase

    if (commit) begin
      ovalid_nxt = 1'b1;
      oaddr_nxt  = idx_r;
      oval_nxt   = commit_val;
      owr_nxt    = 1'b1;
      odone_nxt  = last;
      full_nxt   = full_r || last;
      idx_nxt    = idx_r + 1'b1;
      if (cvalid_r) begin
        if (x_inc == cfg.w) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_inc[PW-1:0];
        end
      end
    end

    if (cfg.width_wr) begin
      cvalid_nxt = 1'b0;
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.pixel_address = oaddr_r;
  assign out_ch.pixel_value   = oval_r;
  assign out_ch.written       = owr_r;
  assign out_ch.image_done    = odone_r;

  always_ff @(posedge clk) begin
    cdvd_r  <= cdvd_nxt;
    crem_r  <= crem_nxt;
    size_r  <= size_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    quo_r   <= quo_nxt;
    oaddr_r <= oaddr_nxt;
    oval_r  <= oval_nxt;
    owr_r   <= owr_nxt;
    odone_r <= odone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lgpf_pkg::BK_IDLE;
      idx_r    <= '0;
      full_r   <= 1'b0;
      cvalid_r <= 1'b1;
      x_r      <= '0;
      y_r      <= '0;
      cnt_r    <= '0;
      dcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      full_r   <= full_nxt;
      cvalid_r <= cvalid_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      cnt_r    <= cnt_nxt;
      dcnt_r   <= dcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/linear_gradient_pixel_filler.sv
// top level of the linear gradient pixel filler
`timescale 1ns / 1ps
`default_nettype none
// Writes pixels of a width x height RGBA8 image in raster order, one result per request.
// A two-entry request queue sits in front of the execution engine, and the result leaves
// through its own register, so the queue can take requests while a result waits. Solid,
// rewind and unused requests complete at one per clock while the output is not stalled.
// A gradient pixel is dequeued, multiplied in the four channel multipliers and divided in
// the shared-step ramp divider, which produces one quotient bit per clock in all four
// channel lanes. After a width register write, the next gradient pixel, unless a rewind
// comes first, recovers its column and row from the pixel index in a bit-serial divider;
// later pixels advance them by counting. The pixel total is registered from the sizes.
module linear_gradient_pixel_filler (
  input  logic                          clk,
  input  logic                          rst_n,
  lgpf_in_if.sink                       in_ch,
  lgpf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgpf_pkg::ADDR_W-1:0]   paddr,
  input  logic [lgpf_pkg::DATA_W-1:0]   pwdata,
  output logic [lgpf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  lgpf_pkg::cfg_t cfg;
  lgpf_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;

  lgpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lgpf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  lgpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
